// ----- design/timestamp_seconds_shifter_assert.svh -----
// Assertion macros for the timestamp seconds shifter.
// Used by the top level; needs nothing else.
`ifndef TIMESTAMP_SECONDS_SHIFTER_ASSERT_SVH
`define TIMESTAMP_SECONDS_SHIFTER_ASSERT_SVH

// The consequent must hold in the same cycle as the trigger.
`define TSS_ASSERT_SAME(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("timestamp_seconds_shifter: same-cycle check failed");

// The consequent must hold in the cycle after the trigger.
`define TSS_ASSERT_NEXT(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("timestamp_seconds_shifter: next-cycle check failed");

`endif

// ----- design/tss_pkg.sv -----
// Shared types and constants for the timestamp seconds shifter.
// Used by tss_state and timestamp_seconds_shifter; depends on nothing.
package tss_pkg;

  localparam int SECONDS_BITS_DEFAULT = 32;
  localparam int PADDR_W = 5;

  localparam logic [7:0]  ZERO_CODE_RESET = 8'd112;
  localparam logic [7:0]  ONE_CODE_RESET  = 8'd113;
  localparam logic [2:0]  THRESHOLD_RESET = 3'd5;
  localparam logic [23:0] TIMEOUT_RESET   = 24'd1100;
  localparam logic [31:0] EPOCH_RESET     = 32'd631152000;

  typedef enum logic [1:0] {
    KIND_SECOND = 2'd0,
    KIND_TIMER  = 2'd1,
    KIND_RESYNC = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_ZERO_CODE = 3'd0,
    REG_ONE_CODE  = 3'd1,
    REG_THRESHOLD = 3'd2,
    REG_TIMEOUT   = 3'd3,
    REG_EPOCH     = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [7:0]  shift_zero_code;
    logic [7:0]  shift_one_code;
    logic [2:0]  stable_threshold;
    logic [23:0] timeout_ticks;
    logic [31:0] epoch_offset;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        sys_time_valid;
    logic [31:0] sys_seconds;
  } item_t;

  typedef struct packed {
    logic               event_valid;
    logic [7:0]         event_code;
    logic               last;
    logic               seconds_stable;
    logic               delta_valid;
    logic signed [31:0] delta_seconds;
    logic [31:0]        next_value;
  } result_t;

  // Status that every result of one item carries.
  typedef struct packed {
    logic               seconds_stable;
    logic               delta_valid;
    logic signed [31:0] delta_seconds;
    logic [31:0]        next_value;
  } status_t;

endpackage

// ----- design/tss_state.sv -----
// Timing state of the seconds shifter: stable count, watchdog, resync, next seconds, last delta.
// Depends on tss_pkg; instantiated by timestamp_seconds_shifter.
module tss_state import tss_pkg::*; #(
  parameter int SECONDS_BITS = SECONDS_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    load,
  input  item_t                   item,
  output logic                    send,
  output logic [SECONDS_BITS-1:0] tosend,
  output status_t                 status
);

  logic [2:0]              stable_count;
  logic                    resync_pending;
  logic [SECONDS_BITS-1:0] next_seconds;
  logic [23:0]             watchdog_count;
  logic                    watchdog_armed;
  logic [31:0]             last_delta;
  logic                    last_delta_valid;

  logic [2:0]              stable_count_next;
  logic                    resync_pending_next;
  logic [SECONDS_BITS-1:0] next_seconds_next;
  logic [23:0]             watchdog_count_next;
  logic                    watchdog_armed_next;
  logic [31:0]             last_delta_next;
  logic                    last_delta_valid_next;

  logic [SECONDS_BITS-1:0] now;
  logic [SECONDS_BITS-1:0] loaded;
  logic [63:0]             diff;
  logic                    ok;

  always_comb begin
    now = SECONDS_BITS'(64'(item.sys_seconds) + 64'(cfg.epoch_offset));
    ok  = stable_count >= cfg.stable_threshold;
    // Resync loads next_seconds before it is sent.
    loaded = (ok && item.sys_time_valid && resync_pending) ? now + 1'b1 : next_seconds;
    diff   = 64'(loaded) - 64'(now);

    stable_count_next     = stable_count;
    resync_pending_next   = resync_pending;
    next_seconds_next     = next_seconds;
    watchdog_count_next   = watchdog_count;
    watchdog_armed_next   = watchdog_armed;
    last_delta_next       = last_delta;
    last_delta_valid_next = last_delta_valid;
    send   = 1'b0;
    tosend = '0;

    case (item.kind)
      KIND_RESYNC: begin
        resync_pending_next = 1'b1;
      end
      KIND_TIMER: begin
        if (watchdog_armed) begin
          if ({1'b0, watchdog_count} + 25'd1 >= {1'b0, cfg.timeout_ticks}) begin
            stable_count_next   = '0;
            watchdog_count_next = '0;
          end else begin
            watchdog_count_next = watchdog_count + 24'd1;
          end
        end
      end
      KIND_SECOND: begin
        if (ok && item.sys_time_valid && resync_pending) begin
          resync_pending_next = 1'b0;
        end
        tosend = ok ? loaded : '0;
        next_seconds_next = loaded + 1'b1;
        send = ok && (loaded != '0);
        if (send && item.sys_time_valid) begin
          last_delta_next       = diff[31:0];
          last_delta_valid_next = 1'b1;
        end else begin
          last_delta_next       = '0;
          last_delta_valid_next = 1'b0;
        end
        if (!ok) begin
          stable_count_next = stable_count + 3'd1;
        end
        watchdog_count_next = '0;
        watchdog_armed_next = 1'b1;
      end
      default: begin
      end
    endcase

    status.seconds_stable = stable_count_next >= cfg.stable_threshold;
    status.delta_valid    = last_delta_valid_next;
    status.delta_seconds  = last_delta_next;
    status.next_value     = 32'(64'(next_seconds_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_count     <= '0;
      resync_pending   <= 1'b1;
      next_seconds     <= '0;
      watchdog_count   <= '0;
      watchdog_armed   <= 1'b0;
      last_delta       <= '0;
      last_delta_valid <= 1'b0;
    end else if (load) begin
      stable_count     <= stable_count_next;
      resync_pending   <= resync_pending_next;
      next_seconds     <= next_seconds_next;
      watchdog_count   <= watchdog_count_next;
      watchdog_armed   <= watchdog_armed_next;
      last_delta       <= last_delta_next;
      last_delta_valid <= last_delta_valid_next;
    end
  end

endmodule

// ----- design/timestamp_seconds_shifter.sv -----
// Top level of the timestamp seconds shifter: APB registers, input stage, output shifter.
// Depends on tss_pkg, tss_state and timestamp_seconds_shifter_assert.svh.
//
// Each item is held in an input register and is processed when it moves into the
// output stage. A second tick that sends yields SECONDS_BITS results, one per cycle
// while result_ready is high, from the output shift register, MSB first; every other
// item yields one result. The output shifter sets the pace, and an item can wait in
// the input register while results are still being taken.
`include "timestamp_seconds_shifter_assert.svh"

module timestamp_seconds_shifter import tss_pkg::*; #(
  parameter int SECONDS_BITS = SECONDS_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               item_valid,
  output logic               item_ready,
  input  item_t              item,
  output logic               result_valid,
  input  logic               result_ready,
  output result_t            result
);

  localparam int CNT_W = $clog2(SECONDS_BITS);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(SECONDS_BITS - 1);

  cfg_t       cfg;
  reg_index_t reg_index;

  item_t held;
  logic  in_full;
  logic  move;

  logic                    snap_send;
  logic [SECONDS_BITS-1:0] snap_tosend;
  status_t                 snap_status;

  logic                    sending;
  logic [CNT_W-1:0]        bit_cnt;
  logic [SECONDS_BITS-1:0] shift_reg;
  status_t                 st;
  logic                    res_last;

  // Configuration port.
  assign pready    = 1'b1;
  assign reg_index = reg_index_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shift_zero_code  <= ZERO_CODE_RESET;
      cfg.shift_one_code   <= ONE_CODE_RESET;
      cfg.stable_threshold <= THRESHOLD_RESET;
      cfg.timeout_ticks    <= TIMEOUT_RESET;
      cfg.epoch_offset     <= EPOCH_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_index)
        REG_ZERO_CODE: cfg.shift_zero_code  <= pwdata[7:0];
        REG_ONE_CODE:  cfg.shift_one_code   <= pwdata[7:0];
        REG_THRESHOLD: cfg.stable_threshold <= pwdata[2:0];
        REG_TIMEOUT:   cfg.timeout_ticks    <= pwdata[23:0];
        REG_EPOCH:     cfg.epoch_offset     <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_ZERO_CODE: prdata = {24'd0, cfg.shift_zero_code};
      REG_ONE_CODE:  prdata = {24'd0, cfg.shift_one_code};
      REG_THRESHOLD: prdata = {29'd0, cfg.stable_threshold};
      REG_TIMEOUT:   prdata = {8'd0, cfg.timeout_ticks};
      REG_EPOCH:     prdata = cfg.epoch_offset;
      default:       prdata = '0;
    endcase
  end

  // Input stage: the held item moves on once the last result ahead of it is taken.
  assign res_last   = !sending || (bit_cnt == LAST_BIT);
  assign move       = in_full && (!result_valid || (result_ready && res_last));
  assign item_ready = !in_full || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_valid && item_ready) begin
      in_full <= 1'b1;
    end else if (move) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held <= item;
    end
  end

  tss_state #(
    .SECONDS_BITS(SECONDS_BITS)
  ) u_state (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .load   (move),
    .item   (held),
    .send   (snap_send),
    .tosend (snap_tosend),
    .status (snap_status)
  );

  // Output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      sending      <= 1'b0;
      bit_cnt      <= '0;
    end else if (move) begin
      result_valid <= 1'b1;
      sending      <= snap_send;
      bit_cnt      <= '0;
    end else if (result_valid && result_ready) begin
      if (res_last) begin
        result_valid <= 1'b0;
        sending      <= 1'b0;
        bit_cnt      <= '0;
      end else begin
        bit_cnt <= bit_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      shift_reg <= snap_tosend;
      st        <= snap_status;
    end else if (result_valid && result_ready && !res_last) begin
      shift_reg <= {shift_reg[SECONDS_BITS-2:0], 1'b0};
    end
  end

  always_comb begin
    result.event_valid    = sending;
    result.event_code     = sending ?
                            (shift_reg[SECONDS_BITS-1] ? cfg.shift_one_code
                                                       : cfg.shift_zero_code) : 8'd0;
    result.last           = res_last;
    result.seconds_stable = st.seconds_stable;
    result.delta_valid    = st.delta_valid;
    result.delta_seconds  = st.delta_seconds;
    result.next_value     = st.next_value;
  end

  `TSS_ASSERT_SAME(a_cnt_only_sending, clk, rst, bit_cnt != '0, sending && result_valid)
  `TSS_ASSERT_SAME(a_move_when_out_empty, clk, rst, in_full && !result_valid, item_ready)
  `TSS_ASSERT_NEXT(a_shift_continues, clk, rst,
                   result_valid && sending && result_ready && !res_last,
                   result_valid && sending)
  `TSS_ASSERT_NEXT(a_drain_empties, clk, rst,
                   result_valid && result_ready && res_last && !in_full,
                   !result_valid)

endmodule

// ----- tb/timestamp_seconds_shifter_tb.sv -----
// Self-checking testbench for timestamp_seconds_shifter: a directed table, then random phases
// under several register settings, with every result checked against a local predictor.
// Depends on tss_pkg and the RTL of the block; reads no files.
module timestamp_seconds_shifter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tss_pkg::*;

  localparam int SEC_BITS = SECONDS_BITS_DEFAULT;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int IDLE_PCT = 23;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int CALM_PHASE = 3;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_DIRECTED = 20;
  localparam int N_SETTINGS = 6;
  // System times that land the loaded seconds value on zero, or one short of the wrap.
  localparam logic [31:0] SYS_LOADS_ZERO = 32'd0 - EPOCH_RESET - 32'd1;
  localparam logic [31:0] SYS_LOADS_MAX  = 32'd0 - EPOCH_RESET - 32'd2;

  typedef struct {
    logic [1:0]  kind;
    logic        tv;
    logic [31:0] sys;
    bit          typed;
    result_t     want;
  } step_row_t;

  typedef struct {
    logic [7:0]  zero_code;
    logic [7:0]  one_code;
    logic [2:0]  threshold;
    logic [23:0] timeout;
    logic [31:0] epoch;
  } setting_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;

  // Register shadow and block state as the predictor sees them.
  logic [7:0]  cfg_zero = ZERO_CODE_RESET;
  logic [7:0]  cfg_one = ONE_CODE_RESET;
  logic [2:0]  cfg_threshold = THRESHOLD_RESET;
  logic [23:0] cfg_timeout = TIMEOUT_RESET;
  logic [31:0] cfg_epoch = EPOCH_RESET;
  logic [2:0]  stable_count = '0;
  logic        resync_pending = 1'b1;
  logic [31:0] next_seconds = '0;
  logic [23:0] watchdog_count = '0;
  logic        watchdog_armed = 1'b0;
  logic [31:0] last_delta = '0;
  logic        last_delta_valid = 1'b0;

  result_t expected_results[$];
  int mismatches = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int shift_bursts = 0;
  int cycle_count = 0;
  bit calm = 1'b0;

  timestamp_seconds_shifter i_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .item_valid, .item_ready, .item, .result_valid, .result_ready, .result
  );

  always #1 clk = ~clk;

  function automatic result_t quiet_status(logic stable, logic [31:0] next_val);
    result_t r;
    r = '0;
    r.last = 1'b1;
    r.seconds_stable = stable;
    r.next_value = next_val;
    return r;
  endfunction

  step_row_t directed_steps [N_DIRECTED] = '{
    '{KIND_TIMER,  1'b0, 32'd0,          1'b1, quiet_status(1'b0, 32'd0)},
    '{KIND_UNUSED, 1'b1, 32'hFFFF_FFFF,  1'b1, quiet_status(1'b0, 32'd0)},
    '{KIND_RESYNC, 1'b1, 32'd0,          1'b1, quiet_status(1'b0, 32'd0)},
    '{KIND_SECOND, 1'b1, 32'd0,          1'b1, quiet_status(1'b0, 32'd1)},
    '{KIND_SECOND, 1'b0, 32'hFFFF_FFFF,  1'b0, '0},
    '{KIND_SECOND, 1'b1, 32'd12345,      1'b0, '0},
    '{KIND_SECOND, 1'b1, 32'hAAAA_AAAA,  1'b0, '0},
    '{KIND_SECOND, 1'b1, 32'h5555_5555,  1'b0, '0},
    '{KIND_SECOND, 1'b1, 32'hFFFF_FFFF,  1'b0, '0},
    '{KIND_SECOND, 1'b0, 32'd0,          1'b0, '0},
    '{KIND_TIMER,  1'b1, 32'hFFFF_FFFF,  1'b0, '0},
    '{KIND_TIMER,  1'b0, 32'd1,          1'b0, '0},
    '{KIND_RESYNC, 1'b0, 32'd0,          1'b0, '0},
    '{KIND_SECOND, 1'b1, SYS_LOADS_ZERO, 1'b1, quiet_status(1'b1, 32'd1)},
    '{KIND_SECOND, 1'b1, 32'd7,          1'b0, '0},
    '{KIND_RESYNC, 1'b1, 32'd0,          1'b0, '0},
    '{KIND_SECOND, 1'b0, 32'd0,          1'b0, '0},
    '{KIND_SECOND, 1'b1, SYS_LOADS_MAX,  1'b0, '0},
    '{KIND_SECOND, 1'b1, 32'd100,        1'b0, '0},
    '{KIND_SECOND, 1'b1, 32'd100,        1'b0, '0}
  };

  setting_t settings [N_SETTINGS] = '{
    '{8'd0,            8'd255,          3'd1,            24'd1,         32'd0},
    '{8'd255,          8'd0,            3'd7,            24'hFF_FFFF,   32'hFFFF_FFFF},
    '{8'h5A,           8'hA5,           3'd0,            24'd0,         32'h8000_0000},
    '{8'h70,           8'h71,           3'd3,            24'd4,         EPOCH_RESET},
    '{8'h0F,           8'hF0,           3'd2,            24'd2,         32'h1234_5678},
    '{ZERO_CODE_RESET, ONE_CODE_RESET,  THRESHOLD_RESET, TIMEOUT_RESET, EPOCH_RESET}
  };

  function automatic item_t make_item(logic [1:0] kind, logic tv, logic [31:0] sys);
    item_t it;
    it.kind = kind;
    it.sys_time_valid = tv;
    it.sys_seconds = sys;
    return it;
  endfunction

  function automatic void push_result(logic ev, logic [7:0] code, logic fin);
    result_t r;
    r.event_valid = ev;
    r.event_code = ev ? code : 8'd0;
    r.last = fin;
    r.seconds_stable = stable_count >= cfg_threshold;
    r.delta_valid = last_delta_valid;
    r.delta_seconds = last_delta_valid ? last_delta : 32'd0;
    r.next_value = next_seconds;
    expected_results.push_back(r);
  endfunction

  // Advances the seconds state by one item and queues the results that it causes.
  function automatic void predict_shift_events(item_t it);
    logic [31:0] now_sec;
    logic [31:0] to_send;
    logic on_time;
    logic sends;
    int b;
    case (it.kind)
      KIND_RESYNC: resync_pending = 1'b1;
      KIND_TIMER: begin
        if (watchdog_armed) begin
          if ({1'b0, watchdog_count} + 25'd1 >= {1'b0, cfg_timeout}) begin
            stable_count = '0;
            watchdog_count = '0;
          end else begin
            watchdog_count = watchdog_count + 24'd1;
          end
        end
      end
      KIND_SECOND: begin
        now_sec = it.sys_seconds + cfg_epoch;
        // Stability is judged on the count as it stood before this tick.
        on_time = stable_count >= cfg_threshold;
        if (on_time && it.sys_time_valid && resync_pending) begin
          next_seconds = now_sec + 32'd1;
          resync_pending = 1'b0;
        end
        to_send = on_time ? next_seconds : 32'd0;
        next_seconds = next_seconds + 32'd1;
        sends = on_time && (to_send != 32'd0);
        if (sends && it.sys_time_valid) begin
          last_delta = to_send - now_sec;
          last_delta_valid = 1'b1;
        end else begin
          last_delta = '0;
          last_delta_valid = 1'b0;
        end
        if (stable_count < cfg_threshold) stable_count = stable_count + 3'd1;
        watchdog_count = '0;
        watchdog_armed = 1'b1;
        if (sends) begin
          for (b = SEC_BITS - 1; b >= 0; b--) begin
            push_result(1'b1, to_send[b] ? cfg_one : cfg_zero, b == 0);
          end
          shift_bursts++;
          return;
        end
      end
      default: ;
    endcase
    push_result(1'b0, 8'd0, 1'b1);
  endfunction

  function automatic logic [31:0] pick_seconds();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd0 - cfg_epoch - 32'd1;
      3: return 32'd0 - cfg_epoch - 32'd2;
      default: return $urandom();
    endcase
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result with nothing expected, got %h", $time, got);
      mismatches++;
      return;
    end
    want = expected_results.pop_front();
    results_checked++;
    compare_field("event_valid", 32'(want.event_valid), 32'(got.event_valid));
    compare_field("event_code", 32'(want.event_code), 32'(got.event_code));
    compare_field("last", 32'(want.last), 32'(got.last));
    compare_field("seconds_stable", 32'(want.seconds_stable), 32'(got.seconds_stable));
    compare_field("delta_valid", 32'(want.delta_valid), 32'(got.delta_valid));
    compare_field("delta_seconds", want.delta_seconds, got.delta_seconds);
    compare_field("next_value", want.next_value, got.next_value);
  endfunction

  // Called right after a rising edge; returns at the edge that accepts the item.
  task automatic drive_item(input item_t it, input bit typed = 1'b0, input result_t want = '0);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predict_shift_events(it);
    if (typed) begin
      void'(expected_results.pop_back());
      expected_results.push_back(want);
    end
    items_accepted++;
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input reg_index_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ZERO_CODE: cfg_zero = value[7:0];
      REG_ONE_CODE:  cfg_one = value[7:0];
      REG_THRESHOLD: cfg_threshold = value[2:0];
      REG_TIMEOUT:   cfg_timeout = value[23:0];
      REG_EPOCH:     cfg_epoch = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_setting(input setting_t s);
    write_register(REG_ZERO_CODE, {24'd0, s.zero_code});
    write_register(REG_ONE_CODE, {24'd0, s.one_code});
    write_register(REG_THRESHOLD, {29'd0, s.threshold});
    write_register(REG_TIMEOUT, {8'd0, s.timeout});
    write_register(REG_EPOCH, s.epoch);
  endtask

  // Mostly runs of second ticks with random content, so the count gets stable and
  // codes go out; timer bursts break stability, resyncs and unused kinds add noise, and the phase drains halfway.
  task automatic run_random_phase(input int count);
    int done_items;
    int roll;
    int burst;
    bit paused;
    done_items = 0;
    paused = 1'b0;
    while (done_items < count) begin
      if (!paused && done_items >= count / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 66) begin
        drive_item(make_item(KIND_SECOND, $urandom_range(0, 99) < 85, pick_seconds()));
        done_items++;
      end else if (roll < 76) begin
        drive_item(make_item(KIND_TIMER, 1'($urandom_range(0, 1)), $urandom()));
        done_items++;
      end else if (roll < 82) begin
        burst = $urandom_range(2, 9);
        repeat (burst) drive_item(make_item(KIND_TIMER, 1'($urandom_range(0, 1)), $urandom()));
        done_items += burst;
      end else if (roll < 93) begin
        drive_item(make_item(KIND_RESYNC, 1'($urandom_range(0, 1)), $urandom()));
        done_items++;
      end else begin
        drive_item(make_item(KIND_UNUSED, 1'($urandom_range(0, 1)), $urandom()));
        done_items++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) check_result(result);
    result_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run stopped at the cycle limit", $time);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    step_row_t row;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      row = directed_steps[i];
      drive_item(make_item(row.kind, row.tv, row.sys), row.typed, row.want);
    end
    wait_drained();

    foreach (settings[p]) begin
      apply_setting(settings[p]);
      calm = (p == CALM_PHASE);
      run_random_phase(ITEMS_PER_PHASE);
      wait_drained();
    end
    calm = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d items through %0d register settings; %0d results checked,",
             items_accepted, N_SETTINGS + 1, results_checked);
    $display("%0d of the second ticks shifted out a full seconds word.", shift_bursts);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/tss_pkg.sv
design/tss_state.sv
design/timestamp_seconds_shifter.sv
tb/timestamp_seconds_shifter_tb.sv
